[src/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CHK_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define CHK_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CHK_PROP(lbl, clk, rst, prop)
`define CHK_NEVER(lbl, clk, rst, expr)
`endif

`endif

[src/prc_pkg.sv]
`default_nettype none

package prc_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 240;
  localparam int RUN_LIMIT     = 240;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 14;
  localparam int COLOR_W = 16;
  localparam int KIND_W  = 2;

  localparam logic [COL_W:0] SCREEN_W_EXT = (COL_W + 1)'(SCREEN_WIDTH);
  localparam logic [ROW_W:0] SCREEN_H_EXT = (ROW_W + 1)'(SCREEN_HEIGHT);
  localparam logic [COL_W-1:0] WIN_X1     = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [CNT_W-1:0] RUN_LIMIT_C = CNT_W'(RUN_LIMIT);
  localparam logic [CNT_W-1:0] MAX_RUN_RESET = CNT_W'(1920);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DESC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one classified input item, expanded into one or two beats by the back end
  typedef struct packed {
    logic               reject;
    logic               has_pix;
    logic               has_desc;
    logic               desc_first;
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   x0;
    logic [ROW_W-1:0]   y0;
    logic [ROW_W-1:0]   y1;
    logic [CNT_W-1:0]   count;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[src/prc_front.sv]
`default_nettype none

`include "assert_macros.svh"

module prc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         req_type,
  input  wire logic [prc_pkg::COL_W-1:0]    pix_x,
  input  wire logic [prc_pkg::ROW_W-1:0]    pix_y,
  input  wire logic [prc_pkg::COLOR_W-1:0]  pix_color,
  input  wire logic                         cfg_wr_en,
  input  wire logic [prc_pkg::CNT_W-1:0]    cfg_wr_data,
  output logic                              push,
  output prc_pkg::op_t                      push_op
);

  logic                        run_open, run_open_next;
  logic [prc_pkg::COL_W-1:0]   start_col, start_col_next;
  logic [prc_pkg::ROW_W-1:0]   start_row, start_row_next;
  logic [prc_pkg::COL_W-1:0]   expect_col, expect_col_next;
  logic [prc_pkg::ROW_W-1:0]   expect_row, expect_row_next;
  logic                        can_continue, can_continue_next;
  logic [prc_pkg::CNT_W-1:0]   run_count, run_count_next;
  logic [prc_pkg::ROW_W-1:0]   last_row, last_row_next;
  logic [prc_pkg::CNT_W-1:0]   max_run;

  logic                        has_run;
  logic                        in_range;
  logic                        cont;
  logic [prc_pkg::CNT_W-1:0]   count_inc;
  logic [prc_pkg::COL_W:0]     x_inc;
  logic [prc_pkg::ROW_W:0]     y_inc;
  logic [prc_pkg::COL_W-1:0]   sc;
  logic [prc_pkg::COL_W-1:0]   exp_col_calc;
  logic [prc_pkg::ROW_W-1:0]   exp_row_calc;
  logic                        can_calc;

  assign has_run   = run_open && (run_count != '0);
  assign in_range  = ({1'b0, pix_x} < prc_pkg::SCREEN_W_EXT) &&
                     ({1'b0, pix_y} < prc_pkg::SCREEN_H_EXT);
  assign cont      = run_open && (run_count < prc_pkg::RUN_LIMIT_C) && can_continue &&
                     (pix_x == expect_col) && (pix_y == expect_row);
  assign count_inc = run_count + 1'b1;
  assign x_inc     = {1'b0, pix_x} + 1'b1;
  assign y_inc     = {1'b0, pix_y} + 1'b1;
  assign sc        = cont ? start_col : pix_x;

  // next expected neighbor, wrapping only for runs that start at column zero
  always_comb begin
    if (x_inc < prc_pkg::SCREEN_W_EXT) begin
      exp_col_calc = x_inc[prc_pkg::COL_W-1:0];
      exp_row_calc = pix_y;
      can_calc     = 1'b1;
    end else if ((sc == '0) && (y_inc < prc_pkg::SCREEN_H_EXT)) begin
      exp_col_calc = '0;
      exp_row_calc = y_inc[prc_pkg::ROW_W-1:0];
      can_calc     = 1'b1;
    end else begin
      exp_col_calc = '0;
      exp_row_calc = '0;
      can_calc     = 1'b0;
    end
  end

  always_comb begin
    run_open_next     = run_open;
    start_col_next    = start_col;
    start_row_next    = start_row;
    expect_col_next   = expect_col;
    expect_row_next   = expect_row;
    can_continue_next = can_continue;
    run_count_next    = run_count;
    last_row_next     = last_row;
    push              = 1'b0;
    push_op           = '0;
    if (accept) begin
      if (req_type == prc_pkg::REQ_FLUSH) begin
        if (has_run) begin
          push               = 1'b1;
          push_op.has_desc   = 1'b1;
          push_op.desc_first = 1'b1;
          push_op.x0         = start_col;
          push_op.y0         = start_row;
          push_op.y1         = last_row;
          push_op.count      = run_count;
        end
        run_open_next  = 1'b0;
        run_count_next = '0;
      end else if (!in_range) begin
        push           = 1'b1;
        push_op.reject = 1'b1;
      end else if (cont) begin
        push              = 1'b1;
        push_op.has_pix   = 1'b1;
        push_op.color     = pix_color;
        run_count_next    = count_inc;
        last_row_next     = pix_y;
        expect_col_next   = exp_col_calc;
        expect_row_next   = exp_row_calc;
        can_continue_next = can_calc;
        if (count_inc >= max_run) begin
          push_op.has_desc = 1'b1;
          push_op.x0       = start_col;
          push_op.y0       = start_row;
          push_op.y1       = pix_y;
          push_op.count    = count_inc;
          run_open_next    = 1'b0;
          run_count_next   = '0;
        end
      end else begin
        push            = 1'b1;
        push_op.has_pix = 1'b1;
        push_op.color   = pix_color;
        if (has_run) begin
          push_op.has_desc   = 1'b1;
          push_op.desc_first = 1'b1;
          push_op.x0         = start_col;
          push_op.y0         = start_row;
          push_op.y1         = last_row;
          push_op.count      = run_count;
        end
        run_open_next     = 1'b1;
        start_col_next    = pix_x;
        start_row_next    = pix_y;
        run_count_next    = prc_pkg::CNT_W'(1);
        last_row_next     = pix_y;
        expect_col_next   = exp_col_calc;
        expect_row_next   = exp_row_calc;
        can_continue_next = can_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open     <= 1'b0;
      start_col    <= '0;
      start_row    <= '0;
      expect_col   <= '0;
      expect_row   <= '0;
      can_continue <= 1'b0;
      run_count    <= '0;
      last_row     <= '0;
      max_run      <= prc_pkg::MAX_RUN_RESET;
    end else begin
      run_open     <= run_open_next;
      start_col    <= start_col_next;
      start_row    <= start_row_next;
      expect_col   <= expect_col_next;
      expect_row   <= expect_row_next;
      can_continue <= can_continue_next;
      run_count    <= run_count_next;
      last_row     <= last_row_next;
      if (cfg_wr_en) begin
        max_run <= cfg_wr_data;
      end
    end
  end

  `CHK_PROP(front_open_has_pixels, clk, rst, run_open |-> (run_count != '0))
  `CHK_NEVER(front_count_over_limit, clk, rst, run_count > prc_pkg::RUN_LIMIT_C)

endmodule

`default_nettype wire

[src/prc_queue.sv]
`default_nettype none

`include "assert_macros.svh"

module prc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire prc_pkg::op_t      push_op,
  input  wire logic              pop,
  output prc_pkg::op_t           head_op,
  output prc_pkg::queue_status_t status
);

  prc_pkg::op_t                  slots [prc_pkg::QUEUE_DEPTH];
  logic [prc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [prc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [prc_pkg::QPTR_W:0]      fill;

  assign status.full  = (fill == (prc_pkg::QPTR_W + 1)'(prc_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head_op      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `CHK_NEVER(queue_push_when_full, clk, rst, push && status.full)
  `CHK_NEVER(queue_pop_when_empty, clk, rst, pop && status.empty)

endmodule

`default_nettype wire

[src/prc_back.sv]
`default_nettype none

`include "assert_macros.svh"

module prc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire prc_pkg::op_t                head_op,
  input  wire prc_pkg::queue_status_t      status,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [prc_pkg::KIND_W-1:0]       out_kind,
  output logic [prc_pkg::COLOR_W-1:0]      out_color,
  output logic [prc_pkg::COL_W-1:0]        win_x0,
  output logic [prc_pkg::ROW_W-1:0]        win_y0,
  output logic [prc_pkg::COL_W-1:0]        win_x1,
  output logic [prc_pkg::ROW_W-1:0]        win_y1,
  output logic [prc_pkg::CNT_W-1:0]        run_pixels,
  output logic                             last
);

  logic phase;
  logic load;
  logic two_beats;
  logic final_beat;
  logic is_desc;

  assign load       = !status.empty && (!out_valid || !out_stall);
  assign two_beats  = !head_op.reject && head_op.has_desc && head_op.has_pix;
  assign final_beat = !two_beats || phase;
  assign pop        = load && final_beat;
  // descriptor slot is the first beat or the second depending on order
  assign is_desc    = head_op.has_desc && (!head_op.has_pix || (head_op.desc_first ^ phase));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !final_beat;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= final_beat;
      if (head_op.reject) begin
        out_kind   <= prc_pkg::KIND_REJECT;
        out_color  <= '0;
        win_x0     <= '0;
        win_y0     <= '0;
        win_x1     <= '0;
        win_y1     <= '0;
        run_pixels <= '0;
      end else if (is_desc) begin
        out_kind   <= prc_pkg::KIND_DESC;
        out_color  <= '0;
        win_x0     <= head_op.x0;
        win_y0     <= head_op.y0;
        win_x1     <= prc_pkg::WIN_X1;
        win_y1     <= head_op.y1;
        run_pixels <= head_op.count;
      end else begin
        out_kind   <= prc_pkg::KIND_PIXEL;
        out_color  <= head_op.color;
        win_x0     <= '0;
        win_y0     <= '0;
        win_x1     <= '0;
        win_y1     <= '0;
        run_pixels <= '0;
      end
    end
  end

  `CHK_PROP(back_desc_not_empty, clk, rst,
            (out_valid && (out_kind == prc_pkg::KIND_DESC)) |-> (run_pixels != '0))

endmodule

`default_nettype wire

[src/pixel_run_coalescer_unit.sv]
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------------
// in       | in_valid / in_stall    | req_type, pix_x, pix_y, pix_color
// out      | out_valid / out_stall  | out_kind, out_color, win_x0..win_y1,
//          |                        | run_pixels, last
// cfg      | cfg_wr_en              | cfg_wr_data (max_run_pixels)
//
// one item is accepted per cycle while in_stall is low; results pass the queue and then the out register
// items with a descriptor and pixel data leave as two output beats from the single out register
// a four deep op queue sits between the classifier and the beat expander
// in_stall rises only when that queue is full, so output stalls reach the input late
// rst is synchronous; it empties the queue, closes any run and reloads max_run_pixels to 1920
`default_nettype none

module pixel_run_coalescer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input beats
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         req_type,
  input  wire logic [prc_pkg::COL_W-1:0]    pix_x,
  input  wire logic [prc_pkg::ROW_W-1:0]    pix_y,
  input  wire logic [prc_pkg::COLOR_W-1:0]  pix_color,
  // run length limit register
  input  wire logic                         cfg_wr_en,
  input  wire logic [prc_pkg::CNT_W-1:0]    cfg_wr_data,
  // result beats
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [prc_pkg::KIND_W-1:0]        out_kind,
  output logic [prc_pkg::COLOR_W-1:0]       out_color,
  output logic [prc_pkg::COL_W-1:0]         win_x0,
  output logic [prc_pkg::ROW_W-1:0]         win_y0,
  output logic [prc_pkg::COL_W-1:0]         win_x1,
  output logic [prc_pkg::ROW_W-1:0]         win_y1,
  output logic [prc_pkg::CNT_W-1:0]         run_pixels,
  output logic                              last
);

  // front to queue
  logic                   push;
  prc_pkg::op_t           push_op;
  // queue to back
  prc_pkg::op_t           head_op;
  prc_pkg::queue_status_t status;
  logic                   pop;
  logic                   accept;

  // input side only waits on queue space
  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  // run tracker: classifies each beat and updates the open run
  prc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .pix_color   (pix_color),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_op     (push_op)
  );

  // decoupling queue of classified ops
  prc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (status)
  );

  // beat expander with the output register
  prc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .status     (status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_color  (out_color),
    .win_x0     (win_x0),
    .win_y0     (win_y0),
    .win_x1     (win_x1),
    .win_y1     (win_y1),
    .run_pixels (run_pixels),
    .last       (last)
  );

endmodule

`default_nettype wire
